[sv/ils_pkg.sv]
`timescale 1ns / 1ps

package ils_pkg;

    localparam int CAPACITY_DEF = 256;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 16;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 9;

    localparam logic [CMD_W-1:0] CMD_READ     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

[sv/ils_ram.sv]
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // registered read; a read of the address written in the same cycle returns the old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sv/indexed_list_store_unit.sv]
`timescale 1ns / 1ps

// Indexed list store: an ordered sequence of up to CAPACITY signed 32-bit
// values, kept as a singly linked list over two single-port-write memories
// (values and next-slot links) with a free list chained through the link
// memory. Each input word is one command (read, insert at head, tail or
// position, delete at position) and gives exactly one result word with the
// read value (-1 unless a read hits), a status and the length after the
// command. After reset the block chains the free list through the link
// memory slot by slot and holds in_stall high meanwhile. A command is
// handled one at a time: reaching position p walks the link chain from
// the head at one link-memory read per cycle, while commands that need no
// walk (range misses, full store) go straight to their result. A finished
// result sits in an output register, so the next command can be taken
// while the previous result waits.

module indexed_list_store_unit #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ils_pkg::CMD_W-1:0]           cmd,
    input  logic signed [ils_pkg::POS_W-1:0]    position,
    input  logic signed [ils_pkg::DATA_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ils_pkg::DATA_W-1:0]   read_value,
    output logic [ils_pkg::STAT_W-1:0]          status,
    output logic [ils_pkg::LEN_W-1:0]           length
);
    import ils_pkg::*;

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W - 1) ? CW : POS_W - 1;

    localparam logic [SW-1:0] SLOT_LAST = SW'(CAPACITY - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(CAPACITY);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_WALK   = 4'd2;
    localparam logic [3:0] S_RDWAIT = 4'd3;
    localparam logic [3:0] S_INS_F  = 4'd4;
    localparam logic [3:0] S_INS_G  = 4'd5;
    localparam logic [3:0] S_INS_B  = 4'd6;
    localparam logic [3:0] S_INS_C  = 4'd7;
    localparam logic [3:0] S_DEL_H  = 4'd8;
    localparam logic [3:0] S_DEL_HB = 4'd9;
    localparam logic [3:0] S_DEL_B  = 4'd10;
    localparam logic [3:0] S_DEL_C  = 4'd11;
    localparam logic [3:0] S_DEL_D  = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    // what follows the end of a walk
    localparam logic [1:0] OP_RD  = 2'd0;
    localparam logic [1:0] OP_INS = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    logic [3:0]        state_reg, state_next;
    logic [SW-1:0]     init_reg, init_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic              first_reg, first_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [SW-1:0]     head_reg, head_next;
    logic [SW-1:0]     free_reg, free_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [1:0]        op_reg, op_next;
    logic              at_head_reg, at_head_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] res_val_reg, res_val_next;
    logic [STAT_W-1:0] res_st_reg, res_st_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_val_reg;
    logic [STAT_W-1:0] out_st_reg;
    logic [LEN_W-1:0]  out_len_reg;

    logic              lk_we, lk_re;
    logic [SW-1:0]     lk_wa, lk_wd, lk_ra, lk_rdata;
    logic              vl_we, vl_re;
    logic [SW-1:0]     vl_wa, vl_ra;
    logic [DATA_W-1:0] vl_wd, vl_rdata;

    logic              accept;
    logic              out_load;
    logic              neg;
    logic [XW-1:0]     p_ext, cnt_ext, ins_pos;
    logic              ins_bad;
    logic [SW-1:0]     cur_now;

    ils_ram #(
        .WIDTH (SW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (lk_we),
        .wr_addr (lk_wa),
        .wr_data (lk_wd),
        .rd_en   (lk_re),
        .rd_addr (lk_ra),
        .rd_data (lk_rdata)
    );

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (vl_we),
        .wr_addr (vl_wa),
        .wr_data (vl_wd),
        .rd_en   (vl_re),
        .rd_addr (vl_ra),
        .rd_data (vl_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // command decode
    assign neg     = position[POS_W-1];
    assign p_ext   = XW'(position[POS_W-2:0]);
    assign cnt_ext = XW'(count_reg);
    assign ins_bad = (cmd == CMD_INS_POS) && !neg && (p_ext > cnt_ext);
    assign ins_pos = ((cmd == CMD_INS_HEAD) || ((cmd == CMD_INS_POS) && neg)) ? '0 :
                     (cmd == CMD_INS_TAIL) ? cnt_ext : p_ext;

    // walk position: the start slot on the first step, then the link just read
    assign cur_now = first_reg ? cur_reg : lk_rdata;

    always_comb
    begin
        state_next   = state_reg;
        init_next    = init_reg;
        cur_next     = cur_reg;
        first_next   = first_reg;
        steps_next   = steps_reg;
        slot_next    = slot_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        at_head_next = at_head_reg;
        val_next     = val_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;
        res_len_next = res_len_reg;

        lk_we = 1'b0;
        lk_wa = slot_reg;
        lk_wd = head_reg;
        lk_re = 1'b0;
        lk_ra = cur_now;
        vl_we = 1'b0;
        vl_wa = free_reg;
        vl_wd = val_reg;
        vl_re = 1'b0;
        vl_ra = cur_now;

        case (state_reg)
            S_INIT:
            begin
                // chain slot i to slot i+1, last back to zero
                lk_we     = 1'b1;
                lk_wa     = init_reg;
                lk_wd     = (init_reg == SLOT_LAST) ? '0 : init_reg + SW'(1);
                init_next = init_reg + SW'(1);
                if (init_reg == SLOT_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    res_val_next = '1;
                    res_st_next  = ST_OK;
                    val_next     = value;
                    cur_next     = head_reg;
                    first_next   = 1'b1;
                    state_next   = S_DONE;
                    case (cmd)
                        CMD_READ:
                        begin
                            if (neg || !(p_ext < cnt_ext))
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else
                            begin
                                op_next    = OP_RD;
                                steps_next = CW'(p_ext);
                                state_next = S_WALK;
                            end
                        end
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS:
                        begin
                            if (ins_bad)
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else if (count_reg == COUNT_MAX)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                count_next   = count_reg + CW'(1);
                                at_head_next = (ins_pos == '0);
                                steps_next   = CW'(ins_pos - XW'(1));
                                op_next      = OP_INS;
                                state_next   = S_INS_F;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (neg || !(p_ext < cnt_ext))
                            begin
                                res_st_next = ST_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (p_ext == '0)
                                begin
                                    state_next = S_DEL_H;
                                end
                                else
                                begin
                                    op_next    = OP_DEL;
                                    steps_next = CW'(p_ext - XW'(1));
                                    state_next = S_WALK;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                    res_len_next = LEN_W'(count_next);
                end
            end
            S_WALK:
            begin
                if (steps_reg == '0)
                begin
                    cur_next = cur_now;
                    case (op_reg)
                        OP_RD:
                        begin
                            vl_re      = 1'b1;
                            state_next = S_RDWAIT;
                        end
                        OP_INS:
                        begin
                            lk_re      = 1'b1;
                            state_next = S_INS_B;
                        end
                        default:
                        begin
                            lk_re      = 1'b1;
                            state_next = S_DEL_B;
                        end
                    endcase
                end
                else
                begin
                    lk_re      = 1'b1;
                    steps_next = steps_reg - CW'(1);
                    first_next = 1'b0;
                end
            end
            S_RDWAIT:
            begin
                res_val_next = vl_rdata;
                state_next   = S_DONE;
            end
            S_INS_F:
            begin
                // take the free slot, fetch its link, store the value
                lk_re      = 1'b1;
                lk_ra      = free_reg;
                vl_we      = 1'b1;
                slot_next  = free_reg;
                state_next = S_INS_G;
            end
            S_INS_G:
            begin
                free_next = lk_rdata;
                if (at_head_reg)
                begin
                    lk_we      = 1'b1;
                    lk_wa      = slot_reg;
                    lk_wd      = head_reg;
                    head_next  = slot_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = head_reg;
                    first_next = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_INS_B:
            begin
                lk_we      = 1'b1;
                lk_wa      = slot_reg;
                lk_wd      = lk_rdata;
                state_next = S_INS_C;
            end
            S_INS_C:
            begin
                lk_we      = 1'b1;
                lk_wa      = cur_reg;
                lk_wd      = slot_reg;
                state_next = S_DONE;
            end
            S_DEL_H:
            begin
                lk_re      = 1'b1;
                lk_ra      = head_reg;
                slot_next  = head_reg;
                state_next = S_DEL_HB;
            end
            S_DEL_HB:
            begin
                head_next  = lk_rdata;
                state_next = S_DEL_D;
            end
            S_DEL_B:
            begin
                // victim is the successor of the previous slot
                slot_next  = lk_rdata;
                lk_re      = 1'b1;
                lk_ra      = lk_rdata;
                state_next = S_DEL_C;
            end
            S_DEL_C:
            begin
                lk_we      = 1'b1;
                lk_wa      = cur_reg;
                lk_wd      = lk_rdata;
                state_next = S_DEL_D;
            end
            S_DEL_D:
            begin
                // return the victim to the free list
                lk_we      = 1'b1;
                lk_wa      = slot_reg;
                lk_wd      = free_reg;
                free_next  = slot_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            init_reg    <= '0;
            first_reg   <= 1'b1;
            steps_reg   <= '0;
            head_reg    <= '0;
            free_reg    <= '0;
            count_reg   <= '0;
            op_reg      <= OP_RD;
            at_head_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            first_reg   <= first_next;
            steps_reg   <= steps_next;
            head_reg    <= head_next;
            free_reg    <= free_next;
            count_reg   <= count_next;
            op_reg      <= op_next;
            at_head_reg <= at_head_next;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        slot_reg    <= slot_next;
        val_reg     <= val_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        res_len_reg <= res_len_next;
    end

    // output register: hold the word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_val_reg <= res_val_reg;
            out_st_reg  <= res_st_reg;
            out_len_reg <= res_len_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_val_reg;
    assign status     = out_st_reg;
    assign length     = out_len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("entry count above capacity");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_valid_reg) |=> out_valid_reg)
        else $error("finished result not moved to output register");

    a_delete_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_DELETE && count_reg == '0) |=>
        (res_st_reg == ST_RANGE && count_reg == '0))
        else $error("delete on empty store not rejected");

endmodule
